// ===== hdl/vaos_pkg.sv =====
package vaos_pkg;

   localparam int DEF_VOICES   = 16;
   localparam int DEF_AGE_BITS = 32;

   localparam int OP_BITS   = 3;
   localparam int NOTE_BITS = 7;
   localparam int FV_BITS   = 4;
   localparam int CHOSEN_BITS = 4;
   localparam int MASK_BITS   = 16;

   localparam int REQ_DATA_BITS = 16;
   localparam int RSP_DATA_BITS = 32;

   localparam int QUEUE_DEPTH = 2;

   localparam logic [OP_BITS-1:0] OP_NOTE_ON  = 3'd0;
   localparam logic [OP_BITS-1:0] OP_NOTE_OFF = 3'd1;
   localparam logic [OP_BITS-1:0] OP_ALL_OFF  = 3'd2;
   localparam logic [OP_BITS-1:0] OP_PLAY     = 3'd3;
   localparam logic [OP_BITS-1:0] OP_STOP     = 3'd4;
   localparam logic [OP_BITS-1:0] OP_FINISHED = 3'd5;

   typedef enum logic [2:0] {
      K_NOTE_ON,
      K_NOTE_OFF,
      K_ALL_OFF,
      K_PLAY,
      K_STOP,
      K_FINISHED,
      K_IGNORE,
      K_NOP
   } kind_type;

   typedef struct packed {
      kind_type               kind;
      logic [NOTE_BITS-1:0]   note;
      logic [FV_BITS-1:0]     fv;
   } cmd_type;

   typedef struct packed {
      logic                   playback_finished;
      logic                   primary_active;
      logic                   any_active;
      logic                   ignored;
      logic [MASK_BITS-1:0]   released_mask;
      logic                   stolen;
      logic                   chosen_valid;
      logic [CHOSEN_BITS-1:0] chosen_voice;
   } rsp_type;

endpackage

// ===== hdl/vaos_front.sv =====
module vaos_front (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [vaos_pkg::REQ_DATA_BITS-1:0] req_tdata,
   input  logic                               csr_wr_en,
   input  logic                               csr_wr_data,
   output logic                               cmd_valid,
   input  logic                               cmd_ready,
   output vaos_pkg::cmd_type                  cmd
);

   localparam int PTR_BITS = $clog2(vaos_pkg::QUEUE_DEPTH);
   localparam int CNT_BITS = $clog2(vaos_pkg::QUEUE_DEPTH + 1);
   localparam logic [CNT_BITS-1:0] FULL = CNT_BITS'(vaos_pkg::QUEUE_DEPTH);

   logic                        sample_loaded_ff, sample_loaded_in;
   vaos_pkg::cmd_type           q_ff [vaos_pkg::QUEUE_DEPTH];
   logic [PTR_BITS-1:0]         wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]         rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0]         cnt_ff, cnt_in;
   logic                        push, pop;
   logic [vaos_pkg::OP_BITS-1:0] op;
   vaos_pkg::cmd_type           classified;

   assign op = req_tdata[vaos_pkg::OP_BITS-1:0];

   always_comb begin
      classified.note = req_tdata[vaos_pkg::OP_BITS +: vaos_pkg::NOTE_BITS];
      classified.fv   = req_tdata[vaos_pkg::OP_BITS + vaos_pkg::NOTE_BITS +: vaos_pkg::FV_BITS];
      unique case (op)
         vaos_pkg::OP_NOTE_ON:
            classified.kind = sample_loaded_ff ? vaos_pkg::K_NOTE_ON : vaos_pkg::K_IGNORE;
         vaos_pkg::OP_PLAY:
            classified.kind = sample_loaded_ff ? vaos_pkg::K_PLAY : vaos_pkg::K_IGNORE;
         vaos_pkg::OP_NOTE_OFF: classified.kind = vaos_pkg::K_NOTE_OFF;
         vaos_pkg::OP_ALL_OFF:  classified.kind = vaos_pkg::K_ALL_OFF;
         vaos_pkg::OP_STOP:     classified.kind = vaos_pkg::K_STOP;
         vaos_pkg::OP_FINISHED: classified.kind = vaos_pkg::K_FINISHED;
         default:               classified.kind = vaos_pkg::K_NOP;
      endcase
   end

   assign req_tready = (cnt_ff != FULL);
   assign cmd_valid  = (cnt_ff != '0);
   assign cmd        = q_ff[rd_ptr_ff];
   assign push       = req_tvalid && req_tready;
   assign pop        = cmd_valid && cmd_ready;

   always_comb begin
      sample_loaded_in = csr_wr_en ? csr_wr_data : sample_loaded_ff;
      wr_ptr_in = push ? wr_ptr_ff + PTR_BITS'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + PTR_BITS'(1) : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + CNT_BITS'(1);
      end else if (pop && !push) begin
         cnt_in = cnt_ff - CNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_loaded_ff <= 1'b0;
         wr_ptr_ff        <= '0;
         rd_ptr_ff        <= '0;
         cnt_ff           <= '0;
      end else begin
         sample_loaded_ff <= sample_loaded_in;
         wr_ptr_ff        <= wr_ptr_in;
         rd_ptr_ff        <= rd_ptr_in;
         cnt_ff           <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= classified;
      end
   end

endmodule

// ===== hdl/vaos_back.sv =====
module vaos_back #(
   parameter int VOICES   = vaos_pkg::DEF_VOICES,
   parameter int AGE_BITS = vaos_pkg::DEF_AGE_BITS
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   output logic              cmd_ready,
   input  vaos_pkg::cmd_type cmd,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output vaos_pkg::rsp_type rsp_data
);

   localparam int VIDX = (VOICES > 1) ? $clog2(VOICES) : 1;
   localparam logic [VIDX-1:0]     LAST    = VIDX'(VOICES - 1);
   localparam logic [AGE_BITS-1:0] AGE_MAX = '1;

   typedef enum logic [3:0] {
      S_IDLE   = 4'b0001,
      S_EXEC   = 4'b0010,
      S_SCAN   = 4'b0100,
      S_COMMIT = 4'b1000
   } state_type;

   state_type                       state_ff, state_in;
   vaos_pkg::cmd_type               item_ff, item_in;
   logic [VOICES-1:0]               active_ff, active_in;
   logic [VOICES-1:0]               primary_ff, primary_in;
   logic [vaos_pkg::NOTE_BITS-1:0]  note_ff [VOICES];
   logic [vaos_pkg::NOTE_BITS-1:0]  note_in [VOICES];
   logic [AGE_BITS-1:0]             age_cnt_ff, age_cnt_in;
   logic [VIDX-1:0]                 scan_idx_ff, scan_idx_in;
   logic                            iss_ff, iss_in;
   logic [VIDX-1:0]                 cmp_idx_ff, cmp_idx_in;
   logic                            cmp_vld_ff, cmp_vld_in;
   logic [VIDX-1:0]                 best_idx_ff, best_idx_in;
   logic [AGE_BITS-1:0]             best_age_ff, best_age_in;
   logic [VIDX-1:0]                 first_ff, first_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   vaos_pkg::rsp_type               rsp_ff, rsp_in;

   logic [AGE_BITS-1:0]             age_mem [VOICES];
   logic [AGE_BITS-1:0]             age_rd_ff;
   logic                            age_we;
   logic [VIDX-1:0]                 age_wa;
   logic [AGE_BITS-1:0]             age_next;

   logic                            out_free;
   logic                            first_cur;
   logic [VOICES-1:0]               idle_vec;
   logic                            free_found;
   logic [VIDX-1:0]                 free_idx;
   logic                            need_steal;
   logic                            take;
   logic                            do_exec;
   logic                            steal;
   logic [VIDX-1:0]                 pick;
   logic [VOICES-1:0]               rel;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign first_cur = active_ff[0] && primary_ff[0];
   assign age_next  = (age_cnt_ff != AGE_MAX) ? age_cnt_ff + AGE_BITS'(1) : age_cnt_ff;
   assign take      = (cmp_idx_ff == first_ff) || (age_rd_ff < best_age_ff);

   always_comb begin
      idle_vec    = ~active_ff;
      idle_vec[0] = idle_vec[0] && !first_cur;
      free_found  = 1'b0;
      free_idx    = '0;
      for (int i = VOICES - 1; i >= 0; i--) begin
         if (idle_vec[i]) begin
            free_found = 1'b1;
            free_idx   = VIDX'(i);
         end
      end
   end

   assign need_steal = (item_ff.kind == vaos_pkg::K_NOTE_ON) && !free_found;

   always_comb begin
      state_in     = state_ff;
      item_in      = item_ff;
      active_in    = active_ff;
      primary_in   = primary_ff;
      note_in      = note_ff;
      age_cnt_in   = age_cnt_ff;
      scan_idx_in  = scan_idx_ff;
      iss_in       = iss_ff;
      cmp_idx_in   = cmp_idx_ff;
      cmp_vld_in   = 1'b0;
      best_idx_in  = best_idx_ff;
      best_age_in  = best_age_ff;
      first_in     = first_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      cmd_ready    = 1'b0;
      do_exec      = 1'b0;
      steal        = 1'b0;
      pick         = free_idx;
      age_we       = 1'b0;
      age_wa       = '0;
      rel          = '0;

      unique case (state_ff)
         S_IDLE: begin
            cmd_ready = 1'b1;
            if (cmd_valid) begin
               item_in  = cmd;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (need_steal) begin
               first_in    = VIDX'(first_cur);
               scan_idx_in = VIDX'(first_cur);
               iss_in      = 1'b1;
               state_in    = S_SCAN;
            end else if (out_free) begin
               do_exec  = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_SCAN: begin
            if (iss_ff) begin
               cmp_idx_in = scan_idx_ff;
               cmp_vld_in = 1'b1;
               if (scan_idx_ff == LAST) begin
                  iss_in = 1'b0;
               end else begin
                  scan_idx_in = scan_idx_ff + VIDX'(1);
               end
            end
            if (cmp_vld_ff) begin
               if (take) begin
                  best_idx_in = cmp_idx_ff;
                  best_age_in = age_rd_ff;
               end
               if (cmp_idx_ff == LAST) begin
                  state_in = S_COMMIT;
               end
            end
         end
         S_COMMIT: begin
            pick  = best_idx_ff;
            steal = 1'b1;
            if (out_free) begin
               do_exec  = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      if (do_exec) begin
         rsp_in = '0;
         unique case (item_ff.kind)
            vaos_pkg::K_NOTE_ON: begin
               active_in[pick]  = 1'b1;
               primary_in[pick] = 1'b0;
               note_in[pick]    = item_ff.note;
               age_cnt_in       = age_next;
               age_we           = 1'b1;
               age_wa           = pick;
               rsp_in.chosen_voice = vaos_pkg::CHOSEN_BITS'(pick);
               rsp_in.chosen_valid = 1'b1;
               rsp_in.stolen       = steal;
            end
            vaos_pkg::K_PLAY: begin
               rsp_in.stolen       = active_ff[0];
               rsp_in.chosen_valid = 1'b1;
               active_in[0]        = 1'b1;
               primary_in[0]       = 1'b1;
               age_cnt_in          = age_next;
               age_we              = 1'b1;
            end
            vaos_pkg::K_NOTE_OFF: begin
               for (int i = 0; i < VOICES; i++) begin
                  rel[i] = active_ff[i] && !primary_ff[i] && (note_ff[i] == item_ff.note);
               end
            end
            vaos_pkg::K_ALL_OFF: rel = active_ff;
            vaos_pkg::K_STOP:    rel = active_ff & primary_ff;
            vaos_pkg::K_FINISHED: begin
               for (int i = 0; i < VOICES; i++) begin
                  if ((int'(item_ff.fv) == i) && active_ff[i]) begin
                     active_in[i]  = 1'b0;
                     primary_in[i] = 1'b0;
                     if (i == 0) begin
                        rsp_in.playback_finished = primary_ff[0];
                     end
                  end
               end
            end
            vaos_pkg::K_IGNORE: rsp_in.ignored = 1'b1;
            vaos_pkg::K_NOP: ;
            default: ;
         endcase
         rsp_in.released_mask  = vaos_pkg::MASK_BITS'(rel);
         rsp_in.any_active     = |active_in;
         rsp_in.primary_active = active_in[0] && primary_in[0];
         rsp_valid_in          = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         active_ff    <= '0;
         primary_ff   <= '0;
         age_cnt_ff   <= '0;
         iss_ff       <= 1'b0;
         cmp_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         active_ff    <= active_in;
         primary_ff   <= primary_in;
         age_cnt_ff   <= age_cnt_in;
         iss_ff       <= iss_in;
         cmp_vld_ff   <= cmp_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      note_ff     <= note_in;
      scan_idx_ff <= scan_idx_in;
      cmp_idx_ff  <= cmp_idx_in;
      best_idx_ff <= best_idx_in;
      best_age_ff <= best_age_in;
      first_ff    <= first_in;
      rsp_ff      <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (age_we) begin
         age_mem[age_wa] <= age_next;
      end
      age_rd_ff <= age_mem[scan_idx_ff];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== hdl/voice_allocator_oldest_steal_top.sv =====
// Channel   Dir  Transfer when         Payload
// req_*     in   tvalid && tready      operation, note, finished_voice
// rsp_*     out  tvalid && tready      one result per request
// csr_*     in   wr_en high            sample_loaded
//
// The executor takes a queued transfer while idle and executes it once the result
// register is free; it takes no new transfer before the last one is executed.
// A note-on with no idle voice first scans the age memory one voice per cycle,
// skipping voice 0 while it is primary, and steals the voice with the lowest age.
// Reset clears all voices, the age counter, the queue and the result valid flag.
// A stalled result holds the executor; the two-entry queue accepts until full.
module voice_allocator_oldest_steal_top #(
   parameter int VOICES   = vaos_pkg::DEF_VOICES,
   parameter int AGE_BITS = vaos_pkg::DEF_AGE_BITS
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // operation[2:0], note[9:3], finished_voice[13:10], zero[15:14]
   input  logic [vaos_pkg::REQ_DATA_BITS-1:0] req_tdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // chosen_voice[3:0], chosen_valid[4], stolen[5], released_mask[21:6],
   // ignored[22], any_active[23], primary_active[24], playback_finished[25], zero[31:26]
   output logic [vaos_pkg::RSP_DATA_BITS-1:0] rsp_tdata,
   input  logic                               csr_wr_en,
   input  logic                               csr_wr_data
);

   logic              cmd_valid;
   logic              cmd_ready;
   vaos_pkg::cmd_type cmd;
   vaos_pkg::rsp_type rsp_data;

   vaos_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .cmd_valid   (cmd_valid),
      .cmd_ready   (cmd_ready),
      .cmd         (cmd)
   );

   vaos_back #(
      .VOICES   (VOICES),
      .AGE_BITS (AGE_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd_ready (cmd_ready),
      .cmd       (cmd),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_data  (rsp_data)
   );

   assign rsp_tdata = vaos_pkg::RSP_DATA_BITS'(rsp_data);

   a_stolen_needs_choice: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_data.stolen |-> rsp_data.chosen_valid)
      else $error("stolen without an assigned voice");

   a_choice_excludes_release: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_data.chosen_valid |-> rsp_data.released_mask == '0 && !rsp_data.ignored)
      else $error("assignment mixed with release or ignore");

   a_primary_implies_any: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_data.primary_active |-> rsp_data.any_active)
      else $error("primary active while no voice active");

   a_finish_clears_primary: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_data.playback_finished |-> !rsp_data.primary_active)
      else $error("primary still active after playback finished");

endmodule
